// ===== src/trg_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trg_pkg
// Shared types, sizes and codes for the timestamp replay guard table.
// ---------------------------------------------------------------------------
package trg_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int KEY_BITS_DEF  = 32;
    localparam int TIME_BITS_DEF = 48;

    localparam int KEY_W   = 32;
    localparam int STAMP_W = 48;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_GRACE    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LIFETIME = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAXREC   = 2'd2;

    localparam logic KIND_CHECK  = 1'b0;
    localparam logic KIND_COMMIT = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_PASSED   = 2'd0,
        VERDICT_GRACE    = 2'd1,
        VERDICT_REORDER  = 2'd2,
        VERDICT_RECORDED = 2'd3
    } verdict_t;

    typedef struct packed {
        logic               kind;
        logic [KEY_W-1:0]   key_id;
        logic [STAMP_W-1:0] stamp_ms;
        logic [STAMP_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]       verdict;
        logic [CNT_W-1:0] records_held;
    } result_t;

    // front decode handed to the back end
    typedef struct packed {
        logic               kind;
        logic               out_of_grace;
        logic [KEY_W-1:0]   key_id;
        logic [STAMP_W-1:0] stamp_ms;
        logic [STAMP_W-1:0] now_ms;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PURGE,
        ST_FIND,
        ST_DROP,
        ST_APPEND,
        ST_REPLY
    } back_state_t;

endpackage
`default_nettype wire

// ===== src/trg_stream_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trg_stream_if
// Valid/ready channel carrying one payload.
// ---------------------------------------------------------------------------
interface trg_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/timestamp_replay_guard_table.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// timestamp_replay_guard_table
// Per-key timestamp anti-replay table with expiry and size limit.
// ---------------------------------------------------------------------------
// A front stage masks the fields, runs the grace test and queues up to two
// items; a back end holds the records oldest first in registers. A check
// purges expired or excess records (one per cycle through the shift of the
// table), then searches and replies; a commit searches, drops the matching
// record or, when the table is full, the oldest, appends and replies. The
// key search compares all slots at once. The result sits in an output
// register so the next item is taken while it waits.
module timestamp_replay_guard_table #(
    parameter int DEPTH     = trg_pkg::DEPTH_DEF,
    parameter int KEY_BITS  = trg_pkg::KEY_BITS_DEF,
    parameter int TIME_BITS = trg_pkg::TIME_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [trg_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [trg_pkg::CFG_W-1:0]   cfg_data,
    trg_stream_if.sink                       in_ch,
    trg_stream_if.source                     out_ch
);
    import trg_pkg::*;

    logic [CFG_W-1:0] grace_reg, life_reg;
    logic [CNT_W-1:0] maxrec_reg;
    logic             job_valid, job_ready;
    job_t             job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg  <= 32'd120000;
            life_reg   <= 32'd3600000;
            maxrec_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRACE:    grace_reg  <= cfg_data;
                CFG_LIFETIME: life_reg   <= cfg_data;
                CFG_MAXREC:   maxrec_reg <= cfg_data[CNT_W-1:0];
                default:      grace_reg  <= grace_reg;
            endcase
        end
    end

    trg_front #(.KEY_BITS(KEY_BITS), .TIME_BITS(TIME_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .grace(grace_reg), .in_ch(in_ch),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    trg_back #(.DEPTH(DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .lifetime(life_reg), .max_rec(maxrec_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

// ===== src/trg_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trg_front
// Masks input fields, runs the grace test and queues jobs (two entries).
// ---------------------------------------------------------------------------
module trg_front #(
    parameter int KEY_BITS  = trg_pkg::KEY_BITS_DEF,
    parameter int TIME_BITS = trg_pkg::TIME_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [trg_pkg::CFG_W-1:0] grace,
    trg_stream_if.sink                   in_ch,
    output logic                         job_valid,
    input  wire logic                    job_ready,
    output trg_pkg::job_t                job
);
    import trg_pkg::*;

    localparam logic [KEY_W-1:0]   KEY_MASK  = KEY_W'({KEY_BITS{1'b1}});
    localparam logic [STAMP_W-1:0] TIME_MASK = STAMP_W'({TIME_BITS{1'b1}});

    job_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next, wr_reg, wr_next;
    job_t       nj;
    logic [STAMP_W-1:0] gap;
    logic       push, pop;

    always_comb
    begin
        nj.kind     = in_ch.payload.kind;
        nj.key_id   = in_ch.payload.key_id & KEY_MASK;
        nj.stamp_ms = in_ch.payload.stamp_ms & TIME_MASK;
        nj.now_ms   = in_ch.payload.now_ms & TIME_MASK;
        gap = (nj.stamp_ms > nj.now_ms) ? nj.stamp_ms - nj.now_ms
                                        : nj.now_ms - nj.stamp_ms;
        nj.out_of_grace = gap > {{(STAMP_W-CFG_W){1'b0}}, grace};
    end

    assign in_ch.ready = cnt_reg != 2'd2;
    assign push = in_ch.valid && in_ch.ready;
    assign job_valid = cnt_reg != 2'd0;
    assign pop = job_valid && job_ready;
    assign job = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= nj;
    end
endmodule
`default_nettype wire

// ===== src/trg_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trg_back
// Record table in shift registers: purge, key search, drop and append.
// ---------------------------------------------------------------------------
module trg_back #(
    parameter int DEPTH = trg_pkg::DEPTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [trg_pkg::CFG_W-1:0] lifetime,
    input  wire logic [trg_pkg::CNT_W-1:0] max_rec,
    input  wire logic                      job_valid,
    output logic                           job_ready,
    input  wire trg_pkg::job_t             job,
    trg_stream_if.source                   out_ch
);
    import trg_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam int CW = (NW > CNT_W) ? NW + 1 : CNT_W + 1;

    logic [KEY_W-1:0]   key_reg   [DEPTH];
    logic [STAMP_W-1:0] stamp_reg [DEPTH];
    logic [STAMP_W-1:0] ref_reg   [DEPTH];
    logic [NW-1:0]      n_reg, n_next;
    back_state_t        st_reg, st_next;
    job_t               j_reg;
    logic               hit_reg;
    logic [PW-1:0]      pos_reg;
    logic [STAMP_W-1:0] hstamp_reg;
    result_t            res_reg, res_next;
    logic               ov_reg, ov_next;

    logic [NW-1:0]      limit;
    logic [STAMP_W:0]   exp_sum;
    logic               purge_one;
    logic               hit_c;
    logic [PW-1:0]      pos_c;
    logic               do_drop, do_app, load;
    logic [PW-1:0]      drop_pos;
    logic [1:0]         verd;

    always_comb
    begin
        limit = (CW'(max_rec) > CW'(DEPTH)) ? NW'(DEPTH) : NW'(max_rec);
        exp_sum = {1'b0, ref_reg[0]} + {{(STAMP_W+1-CFG_W){1'b0}}, lifetime};
        purge_one = (n_reg != '0) &&
                    ((exp_sum <= {1'b0, j_reg.now_ms}) || (n_reg > limit));
    end

    // parallel key match, lowest matching slot wins
    always_comb
    begin
        hit_c = 1'b0;
        pos_c = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (NW'(i) < n_reg && key_reg[i] == j_reg.key_id)
            begin
                hit_c = 1'b1;
                pos_c = PW'(i);
            end
        end
    end

    assign load = job_valid && job_ready;
    assign job_ready = st_reg == ST_IDLE;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:   if (job_valid) st_next = job.kind == KIND_CHECK ? ST_PURGE : ST_FIND;
            ST_PURGE:  if (!purge_one) st_next = ST_FIND;
            ST_FIND:   st_next = j_reg.kind == KIND_CHECK ? ST_REPLY : ST_DROP;
            ST_DROP:   st_next = (hit_reg || n_reg != NW'(DEPTH)) ? ST_APPEND : ST_DROP;
            ST_APPEND: st_next = ST_REPLY;
            ST_REPLY:  if (!ov_reg || out_ch.ready) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        do_drop  = 1'b0;
        do_app   = 1'b0;
        drop_pos = '0;
        n_next   = n_reg;
        case (st_reg)
            ST_PURGE:
            begin
                do_drop = purge_one;
            end
            ST_DROP:
            begin
                if (hit_reg)
                begin
                    do_drop  = 1'b1;
                    drop_pos = pos_reg;
                end
                else if (n_reg == NW'(DEPTH))
                    do_drop = 1'b1;
            end
            ST_APPEND:
            begin
                do_app = 1'b1;
            end
            default:
            begin
                do_drop = 1'b0;
            end
        endcase
        if (do_drop)
            n_next = n_reg - 1'b1;
        if (do_app)
            n_next = n_reg + 1'b1;
    end

    always_comb
    begin
        if (j_reg.kind == KIND_COMMIT)
            verd = VERDICT_RECORDED;
        else if (j_reg.out_of_grace)
            verd = VERDICT_GRACE;
        else if (hit_reg && j_reg.stamp_ms <= hstamp_reg)
            verd = VERDICT_REORDER;
        else
            verd = VERDICT_PASSED;
        res_next = res_reg;
        ov_next  = ov_reg;
        if (ov_reg && out_ch.ready)
            ov_next = 1'b0;
        if (st_reg == ST_REPLY && (!ov_reg || out_ch.ready))
        begin
            ov_next = 1'b1;
            res_next.verdict      = verd;
            res_next.records_held = CNT_W'(n_reg);
        end
    end

    assign out_ch.valid   = ov_reg;
    assign out_ch.payload = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            n_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            n_reg  <= n_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (load)
            j_reg <= job;
        if (st_reg == ST_FIND)
        begin
            hit_reg    <= hit_c;
            pos_reg    <= pos_c;
            hstamp_reg <= stamp_reg[pos_c];
        end
        // shift entries above the dropped slot down by one
        if (do_drop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (PW'(i) >= drop_pos)
                begin
                    key_reg[i]   <= key_reg[i+1];
                    stamp_reg[i] <= stamp_reg[i+1];
                    ref_reg[i]   <= ref_reg[i+1];
                end
            end
        end
        if (do_app)
        begin
            key_reg[PW'(n_reg)]   <= j_reg.key_id;
            stamp_reg[PW'(n_reg)] <= j_reg.stamp_ms;
            ref_reg[PW'(n_reg)]   <= j_reg.now_ms;
        end
    end
endmodule
`default_nettype wire

// ===== src/trg_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trg_checker
// Port-level checks for the replay guard table.
// ---------------------------------------------------------------------------
module trg_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic in_kind,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [1:0] out_verdict,
    input wire logic [6:0] out_held
);
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_verdict))
        else $error("result dropped while stalled");
    ap_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_held <= 7'd64)
        else $error("record count out of range");
    ap_commit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_verdict == 2'd3 |-> out_held != 7'd0)
        else $error("commit left table empty");
    ap_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_kind))
        else $error("input item changed while waiting");
endmodule

bind timestamp_replay_guard_table trg_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.payload.kind),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_verdict(out_ch.payload.verdict), .out_held(out_ch.payload.records_held)
);
`default_nettype wire

// ===== verif/timestamp_replay_guard_table_checker.sv =====
// ---------------------------------------------------------------------------
// timestamp_replay_guard_table_checker
// Watches the item channels and config port of the replay guard, keeps its
// own copy of the record table, predicts each result and compares it.
// ---------------------------------------------------------------------------
module timestamp_replay_guard_table_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [trg_pkg::IDX_W-1:0]     cfg_index,
    input  logic [trg_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  trg_pkg::item_t                in_item,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  trg_pkg::result_t              out_res,
    output int                            fails,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import trg_pkg::*;

    localparam int SLOTS = DEPTH_DEF;

    logic [31:0]        grace_ms;
    logic [31:0]        life_ms;
    logic [CNT_W-1:0]   max_recs;
    logic [KEY_W-1:0]   slot_key[SLOTS];
    logic [STAMP_W-1:0] slot_stamp[SLOTS];
    logic [STAMP_W-1:0] slot_refresh[SLOTS];
    int                 held;
    result_t            verdicts_due[$];

    task automatic report(input string what, input int unsigned want, input int unsigned got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        fails++;
    endtask

    function automatic void drop_slot(input int pos);
        for (int i = pos; i + 1 < held; i++)
        begin
            slot_key[i]     = slot_key[i+1];
            slot_stamp[i]   = slot_stamp[i+1];
            slot_refresh[i] = slot_refresh[i+1];
        end
        held--;
    endfunction

    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < held; i++)
            if (slot_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic bit is_stale(input logic [63:0] refreshed, input logic [63:0] now);
        if (now < {32'd0, life_ms})
            return 1'b0;
        return refreshed <= now - {32'd0, life_ms};
    endfunction

    function automatic result_t guard_step(input item_t it);
        result_t     r;
        logic [63:0] st;
        logic [63:0] nw;
        int          limit;
        int          pos;
        st = {16'd0, it.stamp_ms};
        nw = {16'd0, it.now_ms};
        if (it.kind == KIND_CHECK)
        begin
            limit = (int'(max_recs) < SLOTS) ? int'(max_recs) : SLOTS;
            while (held > 0 && (is_stale({16'd0, slot_refresh[0]}, nw) || held > limit))
                drop_slot(0);
            if ((st > nw && st - nw > {32'd0, grace_ms}) ||
                (st < nw && nw - st > {32'd0, grace_ms}))
                r.verdict = VERDICT_GRACE;
            else
            begin
                pos = find_slot(it.key_id);
                if (pos >= 0 && it.stamp_ms <= slot_stamp[pos])
                    r.verdict = VERDICT_REORDER;
                else
                    r.verdict = VERDICT_PASSED;
            end
        end
        else
        begin
            pos = find_slot(it.key_id);
            if (pos >= 0)
                drop_slot(pos);
            if (held >= SLOTS)
                drop_slot(0);
            slot_key[held]     = it.key_id;
            slot_stamp[held]   = it.stamp_ms;
            slot_refresh[held] = it.now_ms;
            held++;
            r.verdict = VERDICT_RECORDED;
        end
        r.records_held = CNT_W'(held);
        return r;
    endfunction

    initial
    begin
        fails   = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            grace_ms = 32'd120000;
            life_ms  = 32'd3600000;
            max_recs = 7'd64;
            held     = 0;
            verdicts_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRACE:    grace_ms = cfg_data;
                    CFG_LIFETIME: life_ms  = cfg_data;
                    CFG_MAXREC:   max_recs = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                verdicts_due.insert(verdicts_due.size(), guard_step(in_item));
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                    report("unexpected item, verdict", 0, out_res.verdict);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (out_res.verdict !== want.verdict)
                        report("verdict", want.verdict, out_res.verdict);
                    if (out_res.records_held !== want.records_held)
                        report("records_held", want.records_held, out_res.records_held);
                end
            end
        end
        pending = verdicts_due.size();
    end
endmodule

// ===== verif/timestamp_replay_guard_table_tb.sv =====
// ---------------------------------------------------------------------------
// timestamp_replay_guard_table_tb
// Drives directed and random check/commit items through the replay guard
// under several register settings and handshake stall patterns.
// ---------------------------------------------------------------------------
module timestamp_replay_guard_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import trg_pkg::*;

    localparam int          CYCLE_LIMIT = 600000;
    localparam logic [47:0] TIME_MAX    = 48'hFFFF_FFFF_FFFF;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fails;
    int               pending;
    int               cycles;
    int               send_idle_pct;
    int               recv_stall_pct;

    logic [KEY_W-1:0]   key_pool[12];
    logic [STAMP_W-1:0] last_stamp[12];
    logic [63:0]        clock_ms;

    trg_stream_if #(.payload_t(item_t))   in_ch();
    trg_stream_if #(.payload_t(result_t)) out_ch();

    timestamp_replay_guard_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    timestamp_replay_guard_table_checker scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (in_ch.payload),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (out_ch.payload),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timestamp_replay_guard_table regression: fail");
                $finish;
            end
        end
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send(input logic kind, input logic [KEY_W-1:0] key,
                        input logic [STAMP_W-1:0] stamp, input logic [STAMP_W-1:0] now);
        item_t it;
        it.kind     = kind;
        it.key_id   = key;
        it.stamp_ms = stamp;
        it.now_ms   = now;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.payload = it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // wait for the table to go quiet before touching registers
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic set_regs(input logic [31:0] grace, input logic [31:0] life,
                            input logic [31:0] maxrec);
        drain();
        cfg_we    = 1'b1;
        cfg_index = CFG_GRACE;
        cfg_data  = grace;
        @(negedge clk);
        cfg_index = CFG_LIFETIME;
        cfg_data  = life;
        @(negedge clk);
        cfg_index = CFG_MAXREC;
        cfg_data  = maxrec;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_items(input int count, input int commit_heavy,
                                input logic [63:0] step, input logic [63:0] spread);
        int          sel;
        int          k;
        logic [47:0] st;
        logic [47:0] wild;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(11);
            clock_ms += $urandom_range(0, 32'(step));
            if (clock_ms > 64'h0000_8000_0000_0000)
                clock_ms = 64'd50_000_000;
            st = 48'(clock_ms) + 48'($urandom_range(0, 32'(spread)))
                 - 48'($urandom_range(0, 32'(spread)));
            sel = $urandom_range(99);
            wild = 48'({$urandom, $urandom});
            if (commit_heavy != 0 && sel < 60)
            begin
                key_pool[k] = $urandom;
                send(KIND_COMMIT, key_pool[k], st, 48'(clock_ms));
            end
            else if (sel < 70)
            begin
                // usual flow: a check followed by its commit
                send(KIND_CHECK, key_pool[k], st, 48'(clock_ms));
                send(KIND_COMMIT, key_pool[k], st, 48'(clock_ms));
                last_stamp[k] = st;
                n++;
            end
            else if (sel < 85)
                send(KIND_CHECK, key_pool[k], last_stamp[k] + 48'($urandom_range(0, 2))
                     - 48'(1), 48'(clock_ms));
            else if (sel < 92)
                send(KIND_COMMIT, key_pool[k], st, 48'(clock_ms));
            else
                send(1'($urandom), $urandom, wild, 48'({$urandom, $urandom}));
        end
    endtask

    initial
    begin
        logic [47:0] t0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_GRACE;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 17;
        recv_stall_pct = 84;
        clock_ms       = 64'd10_000_000;
        for (int i = 0; i < 12; i++)
        begin
            key_pool[i]   = $urandom;
            last_stamp[i] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part under reset settings
        t0 = 48'd10_000_000;
        send(KIND_CHECK, 32'd0, t0, t0);
        send(KIND_COMMIT, 32'd0, t0, t0);
        send(KIND_CHECK, 32'd0, t0, t0);
        send(KIND_CHECK, 32'd0, t0 - 48'd1, t0);
        send(KIND_CHECK, 32'd0, t0 + 48'd1, t0);
        send(KIND_CHECK, 32'd5, t0 + 48'd120001, t0);
        send(KIND_CHECK, 32'd5, t0 - 48'd120001, t0);
        send(KIND_CHECK, 32'd5, t0 + 48'd120000, t0);
        send(KIND_CHECK, 32'd5, t0 - 48'd120000, t0);
        send(KIND_COMMIT, 32'hFFFF_FFFF, TIME_MAX, t0);
        send(KIND_COMMIT, 32'd7, t0, t0 + 48'd10);
        send(KIND_COMMIT, 32'd0, t0 + 48'd5, t0 + 48'd20);
        send(KIND_CHECK, 32'd0, t0 + 48'd5, t0);
        send(KIND_CHECK, 32'hFFFF_FFFF, 48'd0, 48'd0);
        send(KIND_CHECK, 32'd7, t0, t0 + 48'd3_600_009);
        send(KIND_CHECK, 32'd7, t0 + 48'd3_600_010, t0 + 48'd3_600_010);
        send(KIND_CHECK, 32'hFFFF_FFFF, TIME_MAX, TIME_MAX);
        send(KIND_COMMIT, 32'hA5A5_5A5A, TIME_MAX, TIME_MAX);
        send(KIND_CHECK, 32'hA5A5_5A5A, TIME_MAX, TIME_MAX);
        send(KIND_CHECK, 32'd1, 48'd0, TIME_MAX);
        random_items(240, 0, 64'd20000, 64'd100000);

        set_regs(32'd0, 32'd0, 32'd0);
        send(KIND_COMMIT, 32'd3, 48'd100, 48'd100);
        send(KIND_CHECK, 32'd3, 48'd100, 48'd100);
        send(KIND_CHECK, 32'd3, 48'd101, 48'd100);
        random_items(240, 0, 64'd3, 64'd2);

        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd127);
        random_items(260, 1, 64'd50000, 64'd2_000_000);

        send_idle_pct  = 84;
        recv_stall_pct = 17;
        set_regs(32'd1000, 32'd50000, 32'd8);
        random_items(280, 0, 64'd2000, 64'd900);

        set_regs(32'd120000, 32'd3600000, 32'd64);
        random_items(280, 0, 64'd30000, 64'd100000);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_regs(32'd30, 32'd200, 32'd1);
        random_items(280, 0, 64'd20, 64'd25);

        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100);
        random_items(300, 1, 64'd1000, 64'd5000);

        drain();
        if (fails == 0)
            $display("timestamp_replay_guard_table regression: pass");
        else
            $display("timestamp_replay_guard_table regression: fail");
        $finish;
    end
endmodule
